// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant violated");

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/cosv_pkg.sv -----
// ----------------------------------------------------------------------------
// cosv_pkg
// shared types and constants of the commit object stream validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cosv_pkg;

	localparam int ID_BYTES_DEF = 32;

	localparam logic [6:0]  PARENT_LIMIT  = 7'd64;
	localparam logic [22:0] MESSAGE_LIMIT = 23'd4194304;

	localparam logic [31:0] COMMIT_MAGIC = 32'h5356_4331;
	localparam logic [31:0] NANOS_MAX    = 32'd999999999;

	localparam logic [6:0]  MAX_PARENTS_RST = 7'd64;
	localparam logic [22:0] MAX_MSG_LEN_RST = 23'd4194304;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef enum logic [0:0] {
		REG_MAX_PARENTS = 1'b0,
		REG_MAX_MSG_LEN = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_MAGIC  = 4'd0,
		PH_TREE   = 4'd1,
		PH_PCOUNT = 4'd2,
		PH_PID    = 4'd3,
		PH_SECS   = 4'd4,
		PH_NANOS  = 4'd5,
		PH_LEN    = 4'd6,
		PH_MSG    = 4'd7,
		PH_DONE   = 4'd8
	} phase_t;

	typedef enum logic [3:0] {
		ROLE_MAGIC   = 4'd0,
		ROLE_TREE    = 4'd1,
		ROLE_PCOUNT  = 4'd2,
		ROLE_PID     = 4'd3,
		ROLE_SECS    = 4'd4,
		ROLE_NANOS   = 4'd5,
		ROLE_LEN     = 4'd6,
		ROLE_MSG     = 4'd7,
		ROLE_IGNORED = 4'd8
	} role_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TRUNCATED   = 3'd1,
		ST_BAD_MAGIC   = 3'd2,
		ST_BAD_PARENTS = 3'd3,
		ST_BAD_NANOS   = 3'd4,
		ST_BAD_LENGTH  = 3'd5,
		ST_BAD_TEXT    = 3'd6,
		ST_TRAILING    = 3'd7
	} status_t;

	// continuation range of the next utf-8 byte
	typedef enum logic [1:0] {
		RNG_NORMAL = 2'd0,
		RNG_LOW    = 2'd1,
		RNG_HIGH   = 2'd2
	} utf8_range_t;

	typedef struct packed {
		logic        ok;
		logic [1:0]  pending;
		utf8_range_t next_range;
	} utf8_upd_t;

	function automatic role_t phase_role(input phase_t ph);
		role_t r;
		unique case (ph)
			PH_MAGIC:  r = ROLE_MAGIC;
			PH_TREE:   r = ROLE_TREE;
			PH_PCOUNT: r = ROLE_PCOUNT;
			PH_PID:    r = ROLE_PID;
			PH_SECS:   r = ROLE_SECS;
			PH_NANOS:  r = ROLE_NANOS;
			PH_LEN:    r = ROLE_LEN;
			PH_MSG:    r = ROLE_MSG;
			default:   r = ROLE_IGNORED;
		endcase
		return r;
	endfunction

endpackage

// ----- design/cosv_in_if.sv -----
// ----------------------------------------------------------------------------
// cosv_in_if
// payload byte channel, valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cosv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_byte;

	modport source (output valid, output payload_byte, output last_byte, input ready);
	modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

// ----- design/cosv_out_if.sv -----
// ----------------------------------------------------------------------------
// cosv_out_if
// per-byte result channel, valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cosv_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         byte_role;
	logic [7:0]         byte_echo;
	logic signed [63:0] field_value;
	logic               field_complete;
	logic [5:0]         parent_number;
	logic [2:0]         status;
	logic               object_done;

	modport source (
		output valid, output byte_role, output byte_echo, output field_value,
		output field_complete, output parent_number, output status, output object_done,
		input ready
	);
	modport sink (
		input valid, input byte_role, input byte_echo, input field_value,
		input field_complete, input parent_number, input status, input object_done,
		output ready
	);
endinterface

// ----- design/cosv_utf8.sv -----
// ----------------------------------------------------------------------------
// cosv_utf8
// strict utf-8 byte check, one byte against the pending sequence state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cosv_utf8
	import cosv_pkg::*;
(
	input  logic [7:0]  byte_in,
	input  logic [1:0]  pending,
	input  utf8_range_t next_range,
	output utf8_upd_t   upd
);

	logic [7:0] lo;
	logic [7:0] hi;

	always_comb begin
		upd.ok         = 1'b0;
		upd.pending    = pending;
		upd.next_range = next_range;
		lo             = 8'h80;
		hi             = 8'hBF;
		if (pending == 2'd0) begin
			upd.next_range = RNG_NORMAL;
			priority if (byte_in == 8'h00) begin
				upd.ok = 1'b0;
			end else if (byte_in < 8'h80) begin
				upd.ok = 1'b1;
			end else if (byte_in < 8'hC2) begin
				upd.ok = 1'b0;
			end else if (byte_in < 8'hE0) begin
				upd.ok      = 1'b1;
				upd.pending = 2'd1;
			end else if (byte_in == 8'hE0) begin
				upd.ok         = 1'b1;
				upd.pending    = 2'd2;
				upd.next_range = RNG_LOW;
			end else if (byte_in == 8'hED) begin
				upd.ok         = 1'b1;
				upd.pending    = 2'd2;
				upd.next_range = RNG_HIGH;
			end else if (byte_in < 8'hF0) begin
				upd.ok      = 1'b1;
				upd.pending = 2'd2;
			end else if (byte_in == 8'hF0) begin
				upd.ok         = 1'b1;
				upd.pending    = 2'd3;
				upd.next_range = RNG_LOW;
			end else if (byte_in == 8'hF4) begin
				upd.ok         = 1'b1;
				upd.pending    = 2'd3;
				upd.next_range = RNG_HIGH;
			end else if (byte_in < 8'hF4) begin
				upd.ok      = 1'b1;
				upd.pending = 2'd3;
			end else begin
				upd.ok = 1'b0;
			end
		end else begin
			// overlong, surrogate and above-U+10FFFF guards narrow the second byte
			if (next_range == RNG_LOW) lo = (pending == 2'd2) ? 8'hA0 : 8'h90;
			if (next_range == RNG_HIGH) hi = (pending == 2'd2) ? 8'h9F : 8'h8F;
			if (byte_in >= lo && byte_in <= hi) begin
				upd.ok         = 1'b1;
				upd.pending    = pending - 2'd1;
				upd.next_range = RNG_NORMAL;
			end
		end
	end

endmodule

// ----- design/commit_object_stream_validator_top.sv -----
// ----------------------------------------------------------------------------
// commit_object_stream_validator_top
// streaming validator for commit objects, one payload word in, one result out
//
// data carries one payload byte per word, last_byte marking the final one;
// result carries one word per payload byte: its role, the echoed byte for
// ids and message text, assembled scalar values, parent index and status.
// a byte is registered on entry and parsed against the parser state once
// the output register is free; its result is registered there and held
// until taken. one byte per cycle is sustained while results are taken;
// the parser state lives in flip-flops and is updated once per byte.
// max_parents and max_message_length sit on the apb port at 0x0 and 0x4.
// reset returns the parser to the magic field and both limits to their
// defaults. a stalled result holds the output register; one more byte waits
// in the input register, then data.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module commit_object_stream_validator_top
	import cosv_pkg::*;
#(
	parameter int ID_BYTES = ID_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cosv_in_if.sink               data,
	cosv_out_if.source            result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// byte counter inside an id or scalar field
	localparam int FBC_W = $clog2(ID_BYTES);

	// configuration registers
	logic [6:0]  max_parents_q;
	logic [22:0] max_message_length_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// parser state
	phase_t      phase_q,   phase_n;
	logic [FBC_W-1:0] fbc_q, fbc_n;
	logic [6:0]  parents_expected_q, parents_expected_n;
	logic [6:0]  parents_seen_q,     parents_seen_n;
	logic [63:0] asm_q,     asm_n;
	logic [22:0] msg_rem_q, msg_rem_n;
	logic [1:0]  utf8_pending_q, utf8_pending_n;
	utf8_range_t utf8_range_q,   utf8_range_n;
	status_t     sticky_q,  sticky_n;

	// output register
	logic        res_valid_q;
	role_t       role_q,   role_c;
	logic [7:0]  echo_q,   echo_c;
	logic [63:0] value_q,  value_c;
	logic        comp_q,   comp_c;
	logic [5:0]  pnum_q,   pnum_c;
	status_t     status_q, status_c;
	logic        done_q,   done_c;

	logic        advance;
	logic [6:0]  plimit;
	logic [22:0] mlimit;
	logic [63:0] asm_shift;
	logic [6:0]  seen_inc;
	logic        id_last;
	logic        scalar_last;
	utf8_upd_t   utf8_upd;
	reg_idx_t    cfg_idx;

	// ---------------------------------------------------------------- apb port
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_parents_q        <= MAX_PARENTS_RST;
			max_message_length_q <= MAX_MSG_LEN_RST;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_idx)
				REG_MAX_PARENTS: max_parents_q        <= pwdata[6:0];
				REG_MAX_MSG_LEN: max_message_length_q <= pwdata[22:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_MAX_PARENTS: prdata = {{(APB_DATA_W-7){1'b0}}, max_parents_q};
			REG_MAX_MSG_LEN: prdata = {{(APB_DATA_W-23){1'b0}}, max_message_length_q};
			default:         prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- handshake
	// the parse step fires when a byte is held and the output register is free
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign data.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.ready) begin
			valid_s1 <= data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data.valid && data.ready) begin
			byte_s1 <= data.payload_byte;
			last_s1 <= data.last_byte;
		end
	end

	// ---------------------------------------------------------------- parse step
	assign plimit    = (max_parents_q < PARENT_LIMIT) ? max_parents_q : PARENT_LIMIT;
	assign mlimit    = (max_message_length_q < MESSAGE_LIMIT) ? max_message_length_q
	                                                          : MESSAGE_LIMIT;
	assign asm_shift = {asm_q[55:0], byte_s1};
	assign seen_inc  = parents_seen_q + 7'd1;
	assign id_last   = (fbc_q == FBC_W'(ID_BYTES - 1));
	// seconds are eight bytes, every other scalar four
	assign scalar_last = (phase_q == PH_SECS) ? (fbc_q == FBC_W'(7)) : (fbc_q == FBC_W'(3));

	cosv_utf8 u_utf8 (
		.byte_in    (byte_s1),
		.pending    (utf8_pending_q),
		.next_range (utf8_range_q),
		.upd        (utf8_upd)
	);

	always_comb begin
		phase_n            = phase_q;
		fbc_n              = fbc_q;
		parents_expected_n = parents_expected_q;
		parents_seen_n     = parents_seen_q;
		asm_n              = asm_q;
		msg_rem_n          = msg_rem_q;
		utf8_pending_n     = utf8_pending_q;
		utf8_range_n       = utf8_range_q;
		sticky_n           = sticky_q;
		role_c             = ROLE_IGNORED;
		echo_c             = 8'd0;
		value_c            = 64'd0;
		comp_c             = 1'b0;
		pnum_c             = 6'd0;
		status_c           = ST_OK;
		done_c             = 1'b0;

		if (sticky_q != ST_OK && phase_q != PH_MSG) begin
			// error held: byte ignored until the last one
		end else begin
			unique case (phase_q)
				PH_TREE, PH_PID: begin
					role_c = phase_role(phase_q);
					echo_c = byte_s1;
					if (phase_q == PH_PID) pnum_c = parents_seen_q[5:0];
					if (id_last) begin
						comp_c = 1'b1;
						fbc_n  = '0;
						if (phase_q == PH_TREE) begin
							phase_n = PH_PCOUNT;
						end else begin
							parents_seen_n = seen_inc;
							if (seen_inc >= parents_expected_q) phase_n = PH_SECS;
						end
					end else begin
						fbc_n = fbc_q + FBC_W'(1);
					end
				end
				PH_MSG: begin
					role_c = ROLE_MSG;
					echo_c = byte_s1;
					// text is checked only until the first fault
					if (sticky_q == ST_OK) begin
						utf8_pending_n = utf8_upd.pending;
						utf8_range_n   = utf8_upd.next_range;
						if (!utf8_upd.ok) sticky_n = ST_BAD_TEXT;
					end
					if (msg_rem_q != 23'd0) msg_rem_n = msg_rem_q - 23'd1;
					if (msg_rem_n == 23'd0) begin
						// a sequence cut off by the end of the message
						if (sticky_n == ST_OK && utf8_pending_n != 2'd0) sticky_n = ST_BAD_TEXT;
						phase_n = PH_DONE;
					end
				end
				PH_DONE: begin
					sticky_n = ST_TRAILING;
				end
				default: begin
					role_c = phase_role(phase_q);
					asm_n  = asm_shift;
					if (scalar_last) begin
						comp_c = 1'b1;
						fbc_n  = '0;
						asm_n  = 64'd0;
						unique case (phase_q)
							PH_MAGIC: begin
								value_c = {32'd0, asm_shift[31:0]};
								if (asm_shift[31:0] != COMMIT_MAGIC) sticky_n = ST_BAD_MAGIC;
								else phase_n = PH_TREE;
							end
							PH_PCOUNT: begin
								value_c = {{32{asm_shift[31]}}, asm_shift[31:0]};
								if (asm_shift[31:0] > {25'd0, plimit}) begin
									sticky_n = ST_BAD_PARENTS;
								end else begin
									parents_expected_n = asm_shift[6:0];
									parents_seen_n     = 7'd0;
									phase_n = (asm_shift[6:0] != 7'd0) ? PH_PID : PH_SECS;
								end
							end
							PH_SECS: begin
								value_c = asm_shift;
								phase_n = PH_NANOS;
							end
							PH_NANOS: begin
								value_c = {{32{asm_shift[31]}}, asm_shift[31:0]};
								if (asm_shift[31:0] > NANOS_MAX) sticky_n = ST_BAD_NANOS;
								else phase_n = PH_LEN;
							end
							default: begin
								value_c = {{32{asm_shift[31]}}, asm_shift[31:0]};
								if (asm_shift[31:0] > {9'd0, mlimit}) begin
									sticky_n = ST_BAD_LENGTH;
								end else begin
									msg_rem_n      = asm_shift[22:0];
									utf8_pending_n = 2'd0;
									utf8_range_n   = RNG_NORMAL;
									phase_n = (asm_shift[22:0] != 23'd0) ? PH_MSG : PH_DONE;
								end
							end
						endcase
					end else begin
						fbc_n = fbc_q + FBC_W'(1);
					end
				end
			endcase
		end

		status_c = sticky_n;
		if (last_s1) begin
			// early end: truncation unless a check other than the text check already failed
			if (sticky_n == ST_BAD_TEXT && phase_n == PH_MSG) status_c = ST_TRUNCATED;
			else if (sticky_n == ST_OK && phase_n != PH_DONE) status_c = ST_TRUNCATED;
			if (status_c == ST_OK && phase_n == PH_DONE) done_c = 1'b1;
			phase_n            = PH_MAGIC;
			fbc_n              = '0;
			parents_expected_n = 7'd0;
			parents_seen_n     = 7'd0;
			asm_n              = 64'd0;
			msg_rem_n          = 23'd0;
			utf8_pending_n     = 2'd0;
			utf8_range_n       = RNG_NORMAL;
			sticky_n           = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q            <= PH_MAGIC;
			fbc_q              <= '0;
			parents_expected_q <= 7'd0;
			parents_seen_q     <= 7'd0;
			asm_q              <= 64'd0;
			msg_rem_q          <= 23'd0;
			utf8_pending_q     <= 2'd0;
			utf8_range_q       <= RNG_NORMAL;
			sticky_q           <= ST_OK;
		end else if (advance) begin
			phase_q            <= phase_n;
			fbc_q              <= fbc_n;
			parents_expected_q <= parents_expected_n;
			parents_seen_q     <= parents_seen_n;
			asm_q              <= asm_n;
			msg_rem_q          <= msg_rem_n;
			utf8_pending_q     <= utf8_pending_n;
			utf8_range_q       <= utf8_range_n;
			sticky_q           <= sticky_n;
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			role_q   <= role_c;
			echo_q   <= echo_c;
			value_q  <= value_c;
			comp_q   <= comp_c;
			pnum_q   <= pnum_c;
			status_q <= status_c;
			done_q   <= done_c;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.byte_role      = role_q;
	assign result.byte_echo      = echo_q;
	assign result.field_value    = value_q;
	assign result.field_complete = comp_q;
	assign result.parent_number  = pnum_q;
	assign result.status         = status_q;
	assign result.object_done    = done_q;

	// ---------------------------------------------------------------- checks
	// an accepted object never carries an error status
	`ASSERT_IMPL(a_done_ok, clk, arst_n, res_valid_q && done_q, status_q == ST_OK)
	// ignored bytes only occur with an error or trailing status
	`ASSERT_IMPL(a_ignored_err, clk, arst_n, res_valid_q && role_q == ROLE_IGNORED, status_q != ST_OK)
	// the last byte leaves the parser back at the magic field with no error
	`ASSERT_NEXT(a_last_clears, clk, arst_n, advance && last_s1, phase_q == PH_MAGIC && sticky_q == ST_OK)

endmodule

// ----- bench/commit_result_checker.sv -----
// ----------------------------------------------------------------------------
// commit_result_checker
// watches both word channels and the register port of the commit object
// validator, works out the result word of every accepted payload byte and
// compares it field by field with the word that leaves the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module commit_result_checker
	import cosv_pkg::*;
#(
	parameter int ID_BYTES = ID_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [3:0]            out_role,
	input  logic [7:0]            out_echo,
	input  logic [63:0]           out_value,
	input  logic                  out_complete,
	input  logic [5:0]            out_pnum,
	input  logic [2:0]            out_status,
	input  logic                  out_done,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output int                    errors,
	output int                    results_due
);

	typedef struct packed {
		role_t       role;
		logic [7:0]  echo;
		logic [63:0] value;
		logic        complete;
		logic [5:0]  pnum;
		status_t     status;
		logic        done;
	} byte_result_t;

	byte_result_t pending_results[$];

	logic [6:0]  max_parents;
	logic [22:0] max_msg_len;

	phase_t      phase;
	logic [22:0] field_count;
	logic [6:0]  parents_expected;
	logic [6:0]  parents_seen;
	logic [63:0] acc;
	logic [22:0] msg_left;
	logic [1:0]  u8_pending;
	utf8_range_t u8_range;
	status_t     sticky;

	function automatic void clear_parser();
		phase            = PH_MAGIC;
		field_count      = '0;
		parents_expected = '0;
		parents_seen     = '0;
		acc              = '0;
		msg_left         = '0;
		u8_pending       = '0;
		u8_range         = RNG_NORMAL;
		sticky           = ST_OK;
	endfunction

	// strict utf-8: no overlongs, no surrogates, nothing past U+10FFFF, no NUL
	function automatic logic text_byte_ok(input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'h80;
		hi = 8'hBF;
		if (u8_pending == 2'd0) begin
			u8_range = RNG_NORMAL;
			if (b == 8'h00) return 1'b0;
			if (b < 8'h80) return 1'b1;
			if (b < 8'hC2) return 1'b0;
			if (b < 8'hE0) begin
				u8_pending = 2'd1;
				return 1'b1;
			end
			if (b == 8'hE0) begin
				u8_pending = 2'd2;
				u8_range = RNG_LOW;
				return 1'b1;
			end
			if (b == 8'hED) begin
				u8_pending = 2'd2;
				u8_range = RNG_HIGH;
				return 1'b1;
			end
			if (b < 8'hF0) begin
				u8_pending = 2'd2;
				return 1'b1;
			end
			if (b == 8'hF0) begin
				u8_pending = 2'd3;
				u8_range = RNG_LOW;
				return 1'b1;
			end
			if (b == 8'hF4) begin
				u8_pending = 2'd3;
				u8_range = RNG_HIGH;
				return 1'b1;
			end
			if (b < 8'hF4) begin
				u8_pending = 2'd3;
				return 1'b1;
			end
			return 1'b0;
		end
		if (u8_range == RNG_LOW) lo = (u8_pending == 2'd2) ? 8'hA0 : 8'h90;
		if (u8_range == RNG_HIGH) hi = (u8_pending == 2'd2) ? 8'h9F : 8'h8F;
		if (b < lo || b > hi) return 1'b0;
		u8_pending = u8_pending - 2'd1;
		u8_range = RNG_NORMAL;
		return 1'b1;
	endfunction

	function automatic byte_result_t parse_byte(input logic [7:0] b, input logic last);
		byte_result_t r;
		logic [6:0]   plimit;
		logic [22:0]  mlimit;
		logic [63:0]  word;
		int           width;
		r = '0;
		r.role = ROLE_IGNORED;
		plimit = (max_parents < PARENT_LIMIT) ? max_parents : PARENT_LIMIT;
		mlimit = (max_msg_len < MESSAGE_LIMIT) ? max_msg_len : MESSAGE_LIMIT;
		if (sticky != ST_OK && phase != PH_MSG) begin
			// held error: byte ignored
		end else if (phase == PH_TREE || phase == PH_PID) begin
			r.role = (phase == PH_TREE) ? ROLE_TREE : ROLE_PID;
			r.echo = b;
			if (phase == PH_PID) r.pnum = parents_seen[5:0];
			field_count = field_count + 23'd1;
			if (field_count >= ID_BYTES) begin
				r.complete = 1'b1;
				field_count = '0;
				if (phase == PH_TREE) begin
					phase = PH_PCOUNT;
				end else begin
					parents_seen = parents_seen + 7'd1;
					if (parents_seen >= parents_expected) phase = PH_SECS;
				end
			end
		end else if (phase == PH_MSG) begin
			r.role = ROLE_MSG;
			r.echo = b;
			if (sticky == ST_OK && !text_byte_ok(b)) sticky = ST_BAD_TEXT;
			if (msg_left != 0) msg_left = msg_left - 23'd1;
			if (msg_left == 0) begin
				// a sequence cut off by the end of the message
				if (sticky == ST_OK && u8_pending != 2'd0) sticky = ST_BAD_TEXT;
				phase = PH_DONE;
			end
		end else if (phase == PH_DONE) begin
			sticky = ST_TRAILING;
		end else begin
			width = (phase == PH_SECS) ? 8 : 4;
			r.role = role_t'(phase);
			acc = {acc[55:0], b};
			field_count = field_count + 23'd1;
			if (field_count >= width) begin
				r.complete = 1'b1;
				field_count = '0;
				word = acc;
				acc = '0;
				case (phase)
					PH_MAGIC: begin
						r.value = {32'd0, word[31:0]};
						if (word[31:0] != COMMIT_MAGIC) sticky = ST_BAD_MAGIC;
						else phase = PH_TREE;
					end
					PH_PCOUNT: begin
						r.value = {{32{word[31]}}, word[31:0]};
						if (word[31] || word[31:0] > plimit) begin
							sticky = ST_BAD_PARENTS;
						end else begin
							parents_expected = word[6:0];
							parents_seen = '0;
							phase = (word[6:0] != 0) ? PH_PID : PH_SECS;
						end
					end
					PH_SECS: begin
						r.value = word;
						phase = PH_NANOS;
					end
					PH_NANOS: begin
						r.value = {{32{word[31]}}, word[31:0]};
						if (word[31] || word[31:0] > NANOS_MAX) sticky = ST_BAD_NANOS;
						else phase = PH_LEN;
					end
					default: begin
						r.value = {{32{word[31]}}, word[31:0]};
						if (word[31] || word[31:0] > mlimit) begin
							sticky = ST_BAD_LENGTH;
						end else begin
							msg_left = word[22:0];
							u8_pending = '0;
							u8_range = RNG_NORMAL;
							phase = (word[22:0] != 0) ? PH_MSG : PH_DONE;
						end
					end
				endcase
			end
		end
		r.status = sticky;
		if (last) begin
			if (sticky == ST_BAD_TEXT && phase == PH_MSG) r.status = ST_TRUNCATED;
			else if (sticky == ST_OK && phase != PH_DONE) r.status = ST_TRUNCATED;
			if (r.status == ST_OK && phase == PH_DONE) r.done = 1'b1;
			clear_parser();
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		byte_result_t want;
		if (!arst_n) begin
			pending_results.delete();
			max_parents = MAX_PARENTS_RST;
			max_msg_len = MAX_MSG_LEN_RST;
			clear_parser();
			errors <= 0;
			results_due <= 0;
		end else begin
			// results first: a word leaving now belongs to an older byte
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual role %h status %h",
						$time, out_role, out_status);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("byte_role", want.role, out_role);
					check_field("byte_echo", want.echo, out_echo);
					check_field("field_value", want.value, out_value);
					check_field("field_complete", want.complete, out_complete);
					check_field("parent_number", want.pnum, out_pnum);
					check_field("status", want.status, out_status);
					check_field("object_done", want.done, out_done);
				end
			end
			if (in_valid && in_ready)
				pending_results.insert(pending_results.size(), parse_byte(in_byte, in_last));
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_MAX_PARENTS, 2'b00}) max_parents = pwdata[6:0];
				else if (paddr == {REG_MAX_MSG_LEN, 2'b00}) max_msg_len = pwdata[22:0];
			end
			results_due <= pending_results.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// commit object validator: directed objects for every field check and
// utf-8 corner, then random well-formed and damaged objects under mixed
// sender gaps and receiver stalls; results are checked by the checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import cosv_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	cosv_in_if  data_ch();
	cosv_out_if result_ch();

	// idling mix of the current phase, in percent
	int idle_pct;
	int stall_pct;

	int mismatches;
	int results_due;

	// stimulus bookkeeping for the closing summary
	int objects_sent;
	int bytes_sent;
	int settings_written;

	// current parent limit, so random objects can aim at it
	logic [6:0]  cur_max_parents;

	// object under construction and its message text
	logic [7:0] frame[$];
	logic [7:0] text[$];

	commit_object_stream_validator_top #(
		.ID_BYTES(ID_BYTES_DEF)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.data   (data_ch),
		.result (result_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	commit_result_checker #(
		.ID_BYTES(ID_BYTES_DEF)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (data_ch.valid),
		.in_ready    (data_ch.ready),
		.in_byte     (data_ch.payload_byte),
		.in_last     (data_ch.last_byte),
		.out_valid   (result_ch.valid),
		.out_ready   (result_ch.ready),
		.out_role    (result_ch.byte_role),
		.out_echo    (result_ch.byte_echo),
		.out_value   (result_ch.field_value),
		.out_complete(result_ch.field_complete),
		.out_pnum    (result_ch.parent_number),
		.out_status  (result_ch.status),
		.out_done    (result_ch.object_done),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.errors      (mismatches),
		.results_due (results_due)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// result side: stall at the rate of the current phase
	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("FAIL commit_object_stream_validator_top");
		$finish;
	end

	// ---- object building ----------------------------------------------------

	function automatic void add_frame_byte(input logic [7:0] b);
		frame.insert(frame.size(), b);
	endfunction

	function automatic void add_text_byte(input logic [7:0] b);
		text.insert(text.size(), b);
	endfunction

	function automatic void put32(input logic [31:0] v);
		for (int i = 3; i >= 0; i--) add_frame_byte(v[8*i +: 8]);
	endfunction

	function automatic void put_id();
		repeat (ID_BYTES_DEF) add_frame_byte(8'($urandom_range(0, 255)));
	endfunction

	// header, n_ids raw ids, scalars, length field, then the text as it stands;
	// the count and length fields need not match what follows
	function automatic void build_commit(input logic [31:0] pcount, input int n_ids,
			input logic [63:0] secs, input logic [31:0] nanos, input logic [31:0] len);
		frame.delete();
		put32(COMMIT_MAGIC);
		put_id();
		put32(pcount);
		repeat (n_ids) put_id();
		put32(secs[63:32]);
		put32(secs[31:0]);
		put32(nanos);
		put32(len);
		foreach (text[i]) add_frame_byte(text[i]);
	endfunction

	// one well-formed utf-8 character of random width, corners included
	function automatic void put_char();
		int lead;
		case ($urandom_range(0, 7))
			0, 1, 2: add_text_byte(8'($urandom_range(8'h01, 8'h7F)));
			3: begin
				add_text_byte(8'($urandom_range(8'hC2, 8'hDF)));
				add_text_byte(8'($urandom_range(8'h80, 8'hBF)));
			end
			4: begin
				lead = $urandom_range(8'hE0, 8'hEF);
				add_text_byte(8'(lead));
				if (lead == 8'hE0) add_text_byte(8'($urandom_range(8'hA0, 8'hBF)));
				else if (lead == 8'hED) add_text_byte(8'($urandom_range(8'h80, 8'h9F)));
				else add_text_byte(8'($urandom_range(8'h80, 8'hBF)));
				add_text_byte(8'($urandom_range(8'h80, 8'hBF)));
			end
			default: begin
				lead = $urandom_range(8'hF0, 8'hF4);
				add_text_byte(8'(lead));
				if (lead == 8'hF0) add_text_byte(8'($urandom_range(8'h90, 8'hBF)));
				else if (lead == 8'hF4) add_text_byte(8'($urandom_range(8'h80, 8'h8F)));
				else add_text_byte(8'($urandom_range(8'h80, 8'hBF)));
				add_text_byte(8'($urandom_range(8'h80, 8'hBF)));
				add_text_byte(8'($urandom_range(8'h80, 8'hBF)));
			end
		endcase
	endfunction

	// mostly good objects with random content, some damaged, some plain noise
	function automatic void random_commit();
		int          kind;
		int          plimit;
		int          n;
		logic [31:0] pcount;
		logic [31:0] nanos;
		logic [31:0] len;
		kind = $urandom_range(0, 99);
		plimit = (cur_max_parents < PARENT_LIMIT) ? cur_max_parents : PARENT_LIMIT;
		n = $urandom_range(0, (plimit < 3) ? plimit : 3);
		pcount = n;
		text.delete();
		repeat ($urandom_range(0, 10)) put_char();
		if ($urandom_range(0, 7) == 0)
			text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
		case ($urandom_range(0, 9))
			0: nanos = NANOS_MAX;
			1: nanos = NANOS_MAX + 32'd1;
			2: nanos = $urandom;
			default: nanos = $urandom_range(0, NANOS_MAX);
		endcase
		len = text.size();
		if (kind >= 80 && kind < 86) begin
			// parent count just past the limit, or negative
			pcount = ($urandom_range(0, 1) != 0) ? plimit + 1 : 32'h8000_0000 | $urandom;
			n = 0;
		end else if (kind >= 86 && kind < 92) begin
			// length field off from the text: cut short or trailing text
			len = ($urandom_range(0, 1) != 0) ? len + $urandom_range(1, 3) :
				((len > 0) ? len - 1 : 0);
		end
		build_commit(pcount, n, {$urandom, $urandom}, nanos, len);
		if (kind >= 55 && kind < 65) begin
			// truncated anywhere
			n = $urandom_range(1, frame.size() - 1);
			while (frame.size() > n) frame.delete(frame.size() - 1);
		end else if (kind >= 65 && kind < 72) begin
			repeat ($urandom_range(1, 4)) add_frame_byte(8'($urandom_range(0, 255)));
		end else if (kind >= 72 && kind < 80) begin
			frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (kind >= 92) begin
			frame.delete();
			repeat ($urandom_range(1, 10)) add_frame_byte(8'($urandom_range(0, 255)));
		end
	endfunction

	// ---- driving ---------------------------------------------------------------

	// send the frame as one object, last_byte on its final word
	task automatic send_frame();
		foreach (frame[i]) begin
			while ($urandom_range(0, 99) < idle_pct) begin
				data_ch.valid <= 1'b0;
				@(posedge clk);
			end
			data_ch.valid        <= 1'b1;
			data_ch.payload_byte <= frame[i];
			data_ch.last_byte    <= (i == frame.size() - 1);
			@(posedge clk);
			while (!data_ch.ready) @(posedge clk);
		end
		objects_sent++;
		bytes_sent += frame.size();
	endtask

	// wait until every result word is back and the block is quiet
	task automatic settle();
		data_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// setup phase, access phase, then the bus goes idle
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (idx == REG_MAX_PARENTS) cur_max_parents = value[6:0];
		settings_written++;
	endtask

	// ---- stimulus --------------------------------------------------------------

	initial begin
		int idle_mix[4];
		int stall_mix[4];
		int target;
		idle_mix  = '{0, 65, 0, 10};
		stall_mix = '{0, 0, 65, 10};
		idle_pct = 0;
		stall_pct = 0;
		objects_sent = 0;
		bytes_sent = 0;
		settings_written = 0;
		cur_max_parents = MAX_PARENTS_RST;
		data_ch.valid = 1'b0;
		data_ch.payload_byte = '0;
		data_ch.last_byte = 1'b0;
		result_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// -- directed: reset limits, no idling --

		// single-byte object: cut off in the magic
		frame = '{8'hFF};
		send_frame();
		// wrong magic, then ignored bytes up to the end
		frame = '{8'h53, 8'h56, 8'h43, 8'h30, 8'h00, 8'hFF};
		send_frame();
		// cut off on the first tree id byte
		frame.delete();
		put32(COMMIT_MAGIC);
		add_frame_byte(8'h00);
		send_frame();
		// smallest complete object: no parents, empty message
		text.delete();
		build_commit(0, 0, 64'h8000_0000_0000_0000, NANOS_MAX, 0);
		send_frame();
		// two parents with every utf-8 boundary that is legal
		text = '{8'h41, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
			8'hED, 8'h9F, 8'hBF, 8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
			8'hF4, 8'h8F, 8'hBF, 8'hBF};
		build_commit(2, 2, '1, 0, text.size());
		send_frame();
		// nanos out of range on the very last byte
		text.delete();
		build_commit(0, 0, 0, NANOS_MAX + 32'd1, 0);
		repeat (4) frame.delete(frame.size() - 1);
		send_frame();
		// negative nanos, negative and too large parent counts
		build_commit(0, 0, 1, 32'h8000_0000, 0);
		send_frame();
		build_commit(32'hFFFF_FFFF, 0, 0, 0, 0);
		send_frame();
		build_commit(PARENT_LIMIT + 1, 0, 0, 0, 0);
		send_frame();
		// length at the limit, object ends in the message
		text = '{8'h61, 8'h62, 8'h63};
		build_commit(0, 0, 0, 0, MESSAGE_LIMIT);
		send_frame();
		// length one past the limit
		build_commit(0, 0, 0, 0, MESSAGE_LIMIT + 1);
		send_frame();
		// bytes after a complete object
		text = '{8'h68, 8'h69};
		build_commit(1, 1, 0, 0, 2);
		add_frame_byte(8'h20);
		add_frame_byte(8'h00);
		send_frame();
		// illegal text: overlong, surrogate, above U+10FFFF, bad leads, stray
		// continuation, NUL and sequences cut by the end of the message
		for (int k = 0; k < 12; k++) begin
			case (k)
				0: text = '{8'hE0, 8'h9F, 8'h80};
				1: text = '{8'hED, 8'hA0, 8'h80};
				2: text = '{8'hF0, 8'h8F, 8'h80, 8'h80};
				3: text = '{8'hF4, 8'h90, 8'h80, 8'h80};
				4: text = '{8'hF5, 8'h80};
				5: text = '{8'hC0, 8'h80};
				6: text = '{8'hC1, 8'hBF};
				7: text = '{8'h41, 8'h80};
				8: text = '{8'h41, 8'h00, 8'h42};
				9: text = '{8'hC2, 8'hC0};
				10: text = '{8'h41, 8'hC3};
				default: text = '{8'hF1, 8'h80, 8'h80};
			endcase
			build_commit(0, 0, 0, 0, text.size());
			send_frame();
		end
		// bad text and then an early end: reported as cut short
		text = '{8'hFF, 8'h41, 8'h42};
		build_commit(0, 0, 0, 0, 5);
		send_frame();
		// bad text held over trailing bytes
		text = '{8'hFF};
		build_commit(0, 0, 0, 0, 1);
		add_frame_byte(8'h20);
		send_frame();

		// -- directed: register extremes, upper write bits ignored --
		settle();
		write_reg(REG_MAX_PARENTS, 32'hFFFF_FF80);
		text.delete();
		build_commit(1, 1, 0, 0, 0);
		send_frame();
		build_commit(0, 0, 0, 0, 0);
		send_frame();
		settle();
		write_reg(REG_MAX_PARENTS, 32'd127);
		build_commit(PARENT_LIMIT + 1, 0, 0, 0, 0);
		send_frame();
		build_commit(2, 2, 0, 0, 0);
		send_frame();
		settle();
		write_reg(REG_MAX_MSG_LEN, 32'd0);
		text = '{8'h41};
		build_commit(0, 0, 0, 0, 1);
		send_frame();
		text.delete();
		build_commit(0, 0, 0, 0, 0);
		send_frame();
		settle();
		write_reg(REG_MAX_MSG_LEN, 32'hFF7F_FFFF);
		build_commit(0, 0, 0, 0, MESSAGE_LIMIT + 1);
		send_frame();
		text = '{8'h7A};
		build_commit(0, 0, 0, 0, MESSAGE_LIMIT);
		send_frame();

		// -- random: one phase per idling mix, fresh limits each time --
		for (int p = 0; p < 4; p++) begin
			settle();
			idle_pct = 0;
			stall_pct = 0;
			case ($urandom_range(0, 3))
				0: write_reg(REG_MAX_PARENTS, $urandom_range(0, 127));
				1: write_reg(REG_MAX_PARENTS, PARENT_LIMIT);
				default: write_reg(REG_MAX_PARENTS, $urandom_range(1, 4));
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(REG_MAX_MSG_LEN, $urandom_range(0, 12));
				1: write_reg(REG_MAX_MSG_LEN, 32'h007F_FFFF);
				2: write_reg(REG_MAX_MSG_LEN, MESSAGE_LIMIT);
				default: write_reg(REG_MAX_MSG_LEN, $urandom_range(16, 32'h007F_FFFF));
			endcase
			target = bytes_sent + 64;
			while (bytes_sent < target) begin
				// now and then an object with no idling at all
				if ($urandom_range(0, 7) == 0) begin
					idle_pct = 0;
					stall_pct = 0;
				end else begin
					idle_pct = idle_mix[p];
					stall_pct = stall_mix[p];
				end
				random_commit();
				send_frame();
			end
		end

		// drain and let the pipeline run dry
		settle();
		stall_pct = 0;
		repeat (16) @(posedge clk);
		$display("run covered %0d objects, %0d payload words, %0d register writes",
			objects_sent, bytes_sent, settings_written);
		$display("idle mixes: none, sender gaps, receiver stalls, both; %0d mismatches",
			mismatches);
		if (mismatches == 0) begin
			$display("PASS commit_object_stream_validator_top");
		end else begin
			$display("FAIL commit_object_stream_validator_top");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/cosv_pkg.sv
design/cosv_in_if.sv
design/cosv_out_if.sv
design/cosv_utf8.sv
design/commit_object_stream_validator_top.sv
bench/commit_result_checker.sv
bench/tb.sv
